FILE: rtl/vnorm_pkg.sv
package vnorm_pkg;

    // Largest number of components held for one vector.
    localparam int DIM = 8;
    localparam int IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CNT_W = $clog2(DIM + 1);
    localparam logic [CNT_W-1:0] DIM_CNT = CNT_W'(DIM);

    localparam logic signed [31:0] DIFF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DIFF_MIN = 32'sh8000_0000;
    localparam logic [30:0] UNIT_ONE = 31'h4000_0000;
    localparam logic [4:0] DIV_STEPS = 5'd30;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQ,
        F_ACC
    } f_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQRT,
        B_LOAD,
        B_DIV,
        B_EMIT
    } b_state_t;

    // One finished vector handed from the front part to the back part.
    typedef struct packed {
        logic [63:0] square_sum;
        logic [CNT_W-1:0] count;
        logic overflow;
    } job_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } back_status_t;

endpackage

FILE: rtl/vnorm_front.sv
module vnorm_front (
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  logic signed [31:0] origin_coord,
    input  logic signed [31:0] point_coord,
    input  logic last_element,
    input  vnorm_pkg::back_status_t back_status,
    input  logic [vnorm_pkg::IDX_W-1:0] rd_idx,
    output logic signed [31:0] rd_data,
    output logic front_busy,
    output logic job_valid,
    output vnorm_pkg::job_t job
);

    vnorm_pkg::f_state_t state_reg, state_next;

    logic signed [31:0] diff_mem_reg [vnorm_pkg::DIM];
    logic [31:0] mag_reg;
    logic [63:0] sq_reg;
    logic [63:0] sum_reg;
    logic [vnorm_pkg::CNT_W-1:0] count_reg;
    logic ovf_reg;
    logic keep_reg;
    logic last_reg;
    logic job_valid_reg;
    vnorm_pkg::job_t job_reg;

    logic signed [32:0] diff_wide;
    logic signed [31:0] diff_sat;
    logic [64:0] sum_wide;
    logic [63:0] sum_sat;
    logic room;

    always_comb
    begin
        diff_wide = {point_coord[31], point_coord} - {origin_coord[31], origin_coord};
        if (diff_wide[32] != diff_wide[31])
        begin
            diff_sat = diff_wide[32] ? vnorm_pkg::DIFF_MIN : vnorm_pkg::DIFF_MAX;
        end
        else
        begin
            diff_sat = diff_wide[31:0];
        end
        room = (count_reg < vnorm_pkg::DIM_CNT);
        sum_wide = {1'b0, sum_reg} + {1'b0, sq_reg};
        sum_sat = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vnorm_pkg::F_IDLE: if (accept) state_next = vnorm_pkg::F_SQ;
            vnorm_pkg::F_SQ:   state_next = vnorm_pkg::F_ACC;
            vnorm_pkg::F_ACC:  state_next = vnorm_pkg::F_IDLE;
            default:           state_next = vnorm_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        front_busy = (state_reg != vnorm_pkg::F_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vnorm_pkg::F_IDLE;
            sum_reg <= '0;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (back_status.pop)
            begin
                job_valid_reg <= 1'b0;
            end
            if (state_reg == vnorm_pkg::F_IDLE && accept)
            begin
                if (room)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (state_reg == vnorm_pkg::F_ACC)
            begin
                if (last_reg)
                begin
                    job_valid_reg <= 1'b1;
                    sum_reg <= '0;
                    count_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    sum_reg <= sum_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == vnorm_pkg::F_IDLE && accept)
        begin
            keep_reg <= room;
            last_reg <= last_element;
            mag_reg <= diff_sat[31] ? (~diff_sat + 32'd1) : diff_sat;
            if (room)
            begin
                diff_mem_reg[count_reg[vnorm_pkg::IDX_W-1:0]] <= diff_sat;
            end
        end
        if (state_reg == vnorm_pkg::F_SQ)
        begin
            sq_reg <= keep_reg ? (64'(mag_reg) * 64'(mag_reg)) : 64'd0;
        end
        if (state_reg == vnorm_pkg::F_ACC && last_reg)
        begin
            job_reg.square_sum <= sum_sat;
            job_reg.count <= count_reg;
            job_reg.overflow <= ovf_reg;
        end
    end

    assign rd_data = diff_mem_reg[rd_idx];
    assign job_valid = job_valid_reg;
    assign job = job_reg;

endmodule

FILE: rtl/vnorm_back.sv
module vnorm_back (
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    input  vnorm_pkg::job_t job,
    input  logic signed [31:0] rd_data,
    output logic [vnorm_pkg::IDX_W-1:0] rd_idx,
    output vnorm_pkg::back_status_t back_status,
    output logic result_valid,
    output logic signed [31:0] unit_coord,
    output logic [31:0] vector_norm,
    output logic last_result,
    output logic zero_norm,
    output logic too_long
);

    vnorm_pkg::b_state_t state_reg, state_next;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] root_reg, root_next;
    logic [63:0] probe_reg, probe_next;
    logic [vnorm_pkg::CNT_W-1:0] n_reg;
    logic ovf_reg;
    logic [vnorm_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [31:0] dmag_reg, dmag_next;
    logic neg_reg, neg_next;
    logic sat_reg, sat_next;
    logic [32:0] r_reg, r_next;
    logic [30:0] quo_reg, quo_next;
    logic [4:0] step_reg, step_next;
    logic valid_reg;

    logic [63:0] trial;
    logic [32:0] r_shift;
    logic [31:0] norm;
    logic is_zero;
    logic is_last;
    logic [30:0] q_clip;
    logic [31:0] mag_in;

    assign norm = root_reg[31:0];
    assign is_zero = (norm == 32'd0);
    assign is_last = (vnorm_pkg::CNT_W'(idx_reg) + vnorm_pkg::CNT_W'(1)) == n_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vnorm_pkg::B_IDLE: if (job_valid) state_next = vnorm_pkg::B_SQRT;
            vnorm_pkg::B_SQRT: if (probe_reg[0]) state_next = vnorm_pkg::B_LOAD;
            vnorm_pkg::B_LOAD: state_next = vnorm_pkg::B_DIV;
            vnorm_pkg::B_DIV:
                if (is_zero || sat_reg || step_reg == vnorm_pkg::DIV_STEPS)
                begin
                    state_next = vnorm_pkg::B_EMIT;
                end
            vnorm_pkg::B_EMIT:
                state_next = is_last ? vnorm_pkg::B_IDLE : vnorm_pkg::B_LOAD;
            default: state_next = vnorm_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        rem_next = rem_reg;
        root_next = root_reg;
        probe_next = probe_reg;
        idx_next = idx_reg;
        dmag_next = dmag_reg;
        neg_next = neg_reg;
        sat_next = sat_reg;
        r_next = r_reg;
        quo_next = quo_reg;
        step_next = step_reg;
        trial = root_reg + probe_reg;
        r_shift = {r_reg[31:0], (step_reg == 5'd0) ? dmag_reg[0] : 1'b0};
        mag_in = rd_data[31] ? (~rd_data + 32'd1) : rd_data;
        unique case (state_reg)
            vnorm_pkg::B_IDLE:
            begin
                rem_next = job.square_sum;
                root_next = '0;
                probe_next = 64'h4000_0000_0000_0000;
                idx_next = '0;
            end
            vnorm_pkg::B_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next = rem_reg - trial;
                    root_next = (root_reg >> 1) + probe_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                probe_next = probe_reg >> 2;
            end
            vnorm_pkg::B_LOAD:
            begin
                // Quotient reaches 2^31 or more exactly when mag >= 2 * norm.
                dmag_next = mag_in;
                neg_next = rd_data[31];
                sat_next = ({1'b0, mag_in} >= {norm, 1'b0});
                r_next = {2'b00, mag_in[31:1]};
                quo_next = '0;
                step_next = '0;
            end
            vnorm_pkg::B_DIV:
            begin
                if (r_shift >= {1'b0, norm})
                begin
                    r_next = r_shift - {1'b0, norm};
                    quo_next = {quo_reg[29:0], 1'b1};
                end
                else
                begin
                    r_next = r_shift;
                    quo_next = {quo_reg[29:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
            end
            vnorm_pkg::B_EMIT:
            begin
                idx_next = idx_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vnorm_pkg::B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == vnorm_pkg::B_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        root_reg <= root_next;
        probe_reg <= probe_next;
        idx_reg <= idx_next;
        dmag_reg <= dmag_next;
        neg_reg <= neg_next;
        sat_reg <= sat_next;
        r_reg <= r_next;
        quo_reg <= quo_next;
        step_reg <= step_next;
        if (state_reg == vnorm_pkg::B_IDLE && job_valid)
        begin
            n_reg <= job.count;
            ovf_reg <= job.overflow;
        end
        if (state_reg == vnorm_pkg::B_EMIT)
        begin
            if (is_zero)
            begin
                unit_coord <= '0;
            end
            else
            begin
                unit_coord <= neg_reg ? -$signed({1'b0, q_clip}) : $signed({1'b0, q_clip});
            end
            vector_norm <= norm;
            last_result <= is_last;
            zero_norm <= is_zero;
            too_long <= ovf_reg;
        end
    end

    assign q_clip = (sat_reg || quo_reg > vnorm_pkg::UNIT_ONE) ? vnorm_pkg::UNIT_ONE : quo_reg;
    assign rd_idx = idx_reg;
    assign back_status.busy = (state_reg != vnorm_pkg::B_IDLE);
    assign back_status.pop = (state_reg == vnorm_pkg::B_IDLE) && job_valid;
    assign result_valid = valid_reg;

endmodule

FILE: rtl/vector_normalize_about_origin_top.sv
// Euclidean normalisation of the vector from an origin to a point. Each input beat carries
// one origin component and one point component; their difference (saturated to Q16.16) is
// kept and its square added to a saturating sum. Each beat passes through the front part's
// accept (with difference), square and sum states, and busy is high while it is squared
// and summed. On the beat marked last the back part picks the vector up and takes its
// square root, then emits one result beat per kept component, each the component divided
// by the norm in signed Q2.30. Each component passes through the shared restoring divider
// (load, 31 divide steps, emit); the steps are cut short when the norm is zero or the
// quotient would reach two. Quotients above one are clipped to one. busy stays high from
// the last beat until the cycle in which the final result is shown, because the stored
// differences are in use. Results are shown for one cycle with result_valid; the receiver
// cannot stall and must take them as they come. Components beyond the buffer depth are
// dropped and too_long is reported on every result of that vector.
module vector_normalize_about_origin_top (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic signed [31:0] origin_coord,
    input  logic signed [31:0] point_coord,
    input  logic last_element,
    output logic result_valid,
    output logic signed [31:0] unit_coord,
    output logic [31:0] vector_norm,
    output logic last_result,
    output logic zero_norm,
    output logic too_long
);

    logic front_busy;
    logic job_valid;
    vnorm_pkg::job_t job;
    vnorm_pkg::back_status_t back_status;
    logic [vnorm_pkg::IDX_W-1:0] rd_idx;
    logic signed [31:0] rd_data;
    logic accept;

    // New beats wait while the front part is busy or a vector is queued or being emitted, so the buffer is stable.
    assign busy = front_busy || job_valid || back_status.busy;
    assign accept = start && !busy;

    vnorm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .origin_coord (origin_coord),
        .point_coord  (point_coord),
        .last_element (last_element),
        .back_status  (back_status),
        .rd_idx       (rd_idx),
        .rd_data      (rd_data),
        .front_busy   (front_busy),
        .job_valid    (job_valid),
        .job          (job)
    );

    vnorm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .rd_data      (rd_data),
        .rd_idx       (rd_idx),
        .back_status  (back_status),
        .result_valid (result_valid),
        .unit_coord   (unit_coord),
        .vector_norm  (vector_norm),
        .last_result  (last_result),
        .zero_norm    (zero_norm),
        .too_long     (too_long)
    );

endmodule

FILE: rtl/vnorm_checker.sv
module vnorm_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic result_valid,
    input  logic signed [31:0] unit_coord,
    input  logic [31:0] vector_norm,
    input  logic last_result,
    input  logic zero_norm
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted beat");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |-> busy)
        else $error("result shown while block idle");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |=> !result_valid)
        else $error("results of one vector back to back");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (zero_norm == (vector_norm == 32'd0)))
        else $error("zero_norm disagrees with vector_norm");

    a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_norm |-> unit_coord == 32'sd0)
        else $error("non-zero component with zero norm");

endmodule

bind vector_normalize_about_origin_top vnorm_checker u_vnorm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .unit_coord   (unit_coord),
    .vector_norm  (vector_norm),
    .last_result  (last_result),
    .zero_norm    (zero_norm)
);

FILE: dv/vnorm_checker.sv
`timescale 1ns / 100ps

module vnorm_scoreboard (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic signed [31:0] origin_coord,
    input  logic signed [31:0] point_coord,
    input  logic last_element,
    input  logic result_valid,
    input  logic signed [31:0] unit_coord,
    input  logic [31:0] vector_norm,
    input  logic last_result,
    input  logic zero_norm,
    input  logic too_long,
    output int fail_count,
    output int pending
);

    localparam int EXP_DEPTH = 16;

    typedef struct {
        logic signed [31:0] unit;
        logic [31:0] norm;
        logic last;
        logic zero;
        logic dropped;
    } unit_beat_t;

    logic signed [31:0] diffs [vnorm_pkg::DIM];
    logic [63:0] sum_sq;
    int n_held;
    logic extra_seen;
    unit_beat_t exp_mem [EXP_DEPTH];
    int wr_count;
    int rd_count;

    assign pending = wr_count - rd_count;

    function automatic logic [31:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    task automatic absorb_component(input logic signed [31:0] o, input logic signed [31:0] p,
                                    input logic fin);
        logic signed [33:0] d;
        logic [31:0] mag;
        logic [64:0] s;
        logic [31:0] nrm;
        logic [62:0] q;
        unit_beat_t b;
        d = 34'(p) - 34'(o);
        if (n_held < vnorm_pkg::DIM)
        begin
            if (d > 34'sh7FFF_FFFF) d = 34'sh7FFF_FFFF;
            if (d < -34'sh8000_0000) d = -34'sh8000_0000;
            diffs[n_held] = d[31:0];
            mag = d[33] ? 32'(-d) : d[31:0];
            s = {1'b0, sum_sq} + 65'(64'(mag) * 64'(mag));
            sum_sq = s[64] ? '1 : s[63:0];
            n_held++;
        end
        else
            extra_seen = 1'b1;
        if (fin)
        begin
            nrm = int_sqrt(sum_sq);
            for (int k = 0; k < n_held; k++)
            begin
                d = 34'(diffs[k]);
                b.unit = '0;
                if (nrm != 0)
                begin
                    mag = d[33] ? 32'(-d) : d[31:0];
                    q = (63'(mag) << 30) / 63'(nrm);
                    if (q > (63'd1 << 30)) q = 63'd1 << 30;
                    b.unit = d[33] ? -32'(q) : 32'(q);
                end
                b.norm = nrm;
                b.last = (k + 1 == n_held);
                b.zero = (nrm == 0);
                b.dropped = extra_seen;
                exp_mem[wr_count % EXP_DEPTH] = b;
                wr_count++;
            end
            sum_sq = '0;
            n_held = 0;
            extra_seen = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_sq = '0;
            n_held = 0;
            extra_seen = 1'b0;
            wr_count = 0;
            rd_count = 0;
            fail_count <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (wr_count == rd_count)
                begin
                    $display("%0t: result beat with nothing expected, unit %h", $time,
                             unit_coord);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    unit_beat_t e;
                    e = exp_mem[rd_count % EXP_DEPTH];
                    rd_count++;
                    if (e.unit !== unit_coord || e.norm !== vector_norm ||
                        e.last !== last_result || e.zero !== zero_norm ||
                        e.dropped !== too_long)
                    begin
                        $display("%0t: mismatch, expected unit %h norm %h l%b z%b t%b",
                                 $time, e.unit, e.norm, e.last, e.zero, e.dropped);
                        $display("%0t: mismatch, actual   unit %h norm %h l%b z%b t%b",
                                 $time, unit_coord, vector_norm, last_result, zero_norm,
                                 too_long);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                absorb_component(origin_coord, point_coord, last_element);
        end
    end

endmodule

FILE: dv/tb_vector_normalize_about_origin_top.sv
`timescale 1ns / 100ps

module tb_vector_normalize_about_origin_top;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] origin_coord;
    logic signed [31:0] point_coord;
    logic last_element;
    logic result_valid;
    logic signed [31:0] unit_coord;
    logic [31:0] vector_norm;
    logic last_result;
    logic zero_norm;
    logic too_long;
    int fail_count;
    int pending;
    int cycle_count;
    int beats_sent;

    // The block cannot hold results off, so only the sending side idles.
    vector_normalize_about_origin_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .origin_coord(origin_coord), .point_coord(point_coord),
        .last_element(last_element), .result_valid(result_valid),
        .unit_coord(unit_coord), .vector_norm(vector_norm), .last_result(last_result),
        .zero_norm(zero_norm), .too_long(too_long)
    );

    vnorm_scoreboard u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .origin_coord(origin_coord), .point_coord(point_coord),
        .last_element(last_element), .result_valid(result_valid),
        .unit_coord(unit_coord), .vector_norm(vector_norm), .last_result(last_result),
        .zero_norm(zero_norm), .too_long(too_long),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: ends the run and reports it as failed once cycle_count passes its limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("** vector_normalize_about_origin_top: FAILED **");
            $finish;
        end
    end

    // Drives one beat and holds it until the block takes it. start stays high after the
    // beat is taken; it is lowered only when a gap comes before the next beat, or by
    // idle_inputs, so each signal gets at most one assignment per clock edge.
    task automatic send_beat(input logic [31:0] o, input logic [31:0] p, input logic fin,
                             input bit no_gaps);
        if (!no_gaps && $urandom_range(99) < 26)
        begin
            start <= 1'b0;
            last_element <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 26)
                @(posedge clk);
        end
        start <= 1'b1;
        origin_coord <= o;
        point_coord <= p;
        last_element <= fin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic idle_inputs();
        start <= 1'b0;
        last_element <= 1'b0;
    endtask

    // Random Q16.16 value: mostly modest, sometimes anywhere in the full range.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(131072 * 4)) - 262144);
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(20000000)) - 10000000);
        endcase
    endfunction

    task automatic send_vector(input int len, input bit no_gaps, input bit same);
        logic [31:0] o;
        for (int i = 0; i < len; i++)
        begin
            o = rand_coord();
            send_beat(o, same ? o : rand_coord(), i == len - 1, no_gaps);
        end
    endtask

    initial
    begin
        int len;
        rst_n = 1'b0;
        start = 1'b0;
        origin_coord = '0;
        point_coord = '0;
        last_element = 1'b0;
        cycle_count = 0;
        beats_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a single component, extremes that saturate the difference both ways,
        // a zero vector, a full vector of saturated and zero differences, and an overlong one.
        send_beat(32'h0000_0000, 32'h0001_0000, 1'b1, 1'b0);
        send_beat(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_beat(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
        send_beat(32'h1234_5678, 32'h1234_5678, 1'b0, 1'b0);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        for (int i = 0; i < vnorm_pkg::DIM; i++)
            send_beat(32'h8000_0000, i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                      i == vnorm_pkg::DIM - 1, 1'b0);
        for (int i = 0; i < vnorm_pkg::DIM + 3; i++)
            send_beat(32'($signed(i) * -65536), 32'($signed(i) * 3 * 65536),
                      i == vnorm_pkg::DIM + 2, 1'b0);
        idle_inputs();

        // Hold off until every expected result has come out.
        while (pending != 0)
            @(posedge clk);

        // Random vectors; a stretch in the middle runs with no gaps at all.
        while (beats_sent < 330)
        begin
            len = ($urandom_range(9) == 0) ? vnorm_pkg::DIM + $urandom_range(1, 3)
                                           : $urandom_range(1, vnorm_pkg::DIM);
            send_vector(len, beats_sent > 120 && beats_sent < 200,
                        $urandom_range(15) == 0);
        end
        idle_inputs();

        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("** vector_normalize_about_origin_top: PASSED **");
        else
            $display("** vector_normalize_about_origin_top: FAILED **");
        $finish;
    end

endmodule
